// File: rtl/core/dsv_pkg.sv
package dsv_pkg;

  localparam int WORD_W            = 32;
  localparam int SYM_W             = 5;
  localparam int MOD_BITS_DEF      = 32;
  localparam int SYMBOL_COUNT_DEF  = 32;
  localparam logic [WORD_W-1:0] HASH_MIN_MOD      = 32'd32;
  localparam logic [WORD_W-1:0] HASH_FALLBACK_MOD = 32'd257;
  localparam logic [WORD_W-1:0] HASH_MOD_RESET    = 32'd101;

  localparam logic [2:0] REG_PRIME_P     = 3'd0;
  localparam logic [2:0] REG_PRIME_Q     = 3'd1;
  localparam logic [2:0] REG_GENERATOR_A = 3'd2;
  localparam logic [2:0] REG_SECRET_KEY  = 3'd3;
  localparam logic [2:0] REG_PUBLIC_KEY  = 3'd4;
  localparam logic [2:0] REG_HASH_MOD    = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_R_ZERO  = 3'd2;
  localparam logic [2:0] ST_S_ZERO  = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;
  localparam logic [2:0] ST_NONCE   = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE, S_START, S_HASH_ADD, S_HASH_SQR, S_MWAIT, S_CHECK_LAST,
    S_SIGN_CHK, S_VER_CHK, S_HM_RED, S_HM_FIX,
    S_R_SET, S_R_SAVE, S_R_RED, S_R_CHK, S_XR, S_KH, S_S_ADD, S_S_CHK,
    S_V_SET, S_V_SAVE, S_Z1, S_Z2, S_PA_SET, S_PA_SAVE, S_PY_SET,
    S_PROD_CHK, S_PROD, S_U,
    S_POW_INIT, S_POW_BASE, S_POW_LOOP, S_POW_MUL, S_POW_SQR, S_POW_SHIFT,
    S_EMIT_NONCE, S_EMIT_RZERO, S_EMIT_SZERO, S_EMIT_SIGN, S_EMIT_RANGE,
    S_EMIT_VERIFY
  } state_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_HASH_ADD, OP_HASH_SQR, OP_FINISH_HASH,
    OP_HM_RED, OP_HM_FIX,
    OP_POW_SET_R, OP_POW_SET_V, OP_POW_SET_Z1, OP_POW_SET_Z2,
    OP_POW_INIT, OP_POW_BASE, OP_POW_MUL, OP_POW_SQR, OP_POW_SHIFT,
    OP_SAVE_R, OP_SAVE_V, OP_SAVE_PA,
    OP_R_RED, OP_XR, OP_KH, OP_S_ADD, OP_Z1, OP_Z2, OP_PROD, OP_U,
    OP_EMIT_NONCE, OP_EMIT_RZERO, OP_EMIT_SZERO, OP_EMIT_SIGN,
    OP_EMIT_RANGE, OP_EMIT_VERIFY
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic last;
    logic act;
    logic foreign;
    logic k_bad;
    logic sig_bad;
    logic pmod_zero;
    logic pe_zero;
    logic pe_lsb;
    logic r_zero;
    logic s_zero;
    logic p_zero;
    logic out_full;
  } flags_t;

endpackage

// File: rtl/core/dsv_modmul.sv
module dsv_modmul import dsv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W:0]   x,
  input  logic [WORD_W-1:0] y,
  input  logic [WORD_W-1:0] m,
  output logic              done,
  output logic [WORD_W-1:0] res
);

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic [WORD_W:0]   xs;
  logic [WORD_W-1:0] yr;
  logic [WORD_W-1:0] mr;
  logic [CNT_W-1:0]  cnt;
  logic              phase;
  logic              run;
  logic [WORD_W:0]   dbl;
  logic [WORD_W:0]   add;
  logic [WORD_W:0]   pick;
  logic [WORD_W-1:0] red;

  assign dbl  = {res, 1'b0};
  assign add  = xs[WORD_W] ? ({1'b0, res} + {1'b0, yr}) : {1'b0, res};
  assign pick = phase ? add : dbl;
  assign red  = (pick >= {1'b0, mr}) ? WORD_W'(pick - {1'b0, mr}) : pick[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        phase <= 1'b0;
        cnt   <= CNT_W'(WORD_W);
        xs    <= x;
        yr    <= y;
        mr    <= m;
        res   <= '0;
      end else if (run) begin
        res   <= red;
        phase <= ~phase;
        if (phase) begin
          xs <= {xs[WORD_W-1:0], 1'b0};
          if (cnt == '0) begin
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/dsv_datapath.sv
module dsv_datapath import dsv_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output flags_t            flags,
  input  logic [WORD_W-1:0] p,
  input  logic [WORD_W-1:0] q,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] xkey,
  input  logic [WORD_W-1:0] ykey,
  input  logic [WORD_W-1:0] hash_mod_raw,
  input  logic [WORD_W-1:0] op_mask,
  input  logic              in_action,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_last,
  input  logic [WORD_W-1:0] in_nonce,
  input  logic [WORD_W-1:0] in_sig_r,
  input  logic [WORD_W-1:0] in_sig_s,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [WORD_W-1:0] out_r,
  output logic [WORD_W-1:0] out_s,
  output logic [WORD_W-1:0] out_hash
);

  typedef enum logic [3:0] {
    D_SUM, D_H, D_HM, D_R, D_S, D_T, D_Z1, D_Z2, D_PB, D_PRES
  } dst_t;

  logic [WORD_W-1:0] h, hf, sum, hm, r, s, t, v, z1, z2, pa, pb, pe, pres;
  logic [WORD_W-1:0] k, sr, ss;
  logic [SYM_W-1:0]  sym;
  logic              act, last, pmsel;
  dst_t              dst, mdst;
  logic              mul_go, mul_done;
  logic [WORD_W:0]   mx;
  logic [WORD_W-1:0] my, mm, mres, hmod, pmod;
  logic [WORD_W:0]   s_sum;

  assign hmod  = (hash_mod_raw < HASH_MIN_MOD) ? HASH_FALLBACK_MOD : hash_mod_raw;
  assign pmod  = pmsel ? q : p;
  assign s_sum = {1'b0, s} + {1'b0, t};

  always_comb begin
    mul_go = 1'b1;
    mx     = {1'b0, pb};
    my     = 32'd1;
    mm     = pmod;
    mdst   = D_PB;
    case (cmd.op)
      OP_HASH_ADD: begin
        mx = {1'b0, h} + (WORD_W+1)'(sym) + 1'b1; mm = hmod; mdst = D_SUM;
      end
      OP_HASH_SQR: begin mx = {1'b0, sum}; my = sum; mm = hmod; mdst = D_H; end
      OP_HM_RED:   begin mx = {1'b0, hf}; mm = q; mdst = D_HM; end
      OP_POW_BASE: begin mdst = D_PB; end
      OP_POW_MUL:  begin mx = {1'b0, pres}; my = pb; mdst = D_PRES; end
      OP_POW_SQR:  begin my = pb; mdst = D_PB; end
      OP_R_RED:    begin mx = {1'b0, r}; mm = q; mdst = D_R; end
      OP_XR:       begin mx = {1'b0, xkey}; my = r; mm = q; mdst = D_S; end
      OP_KH:       begin mx = {1'b0, k}; my = hm; mm = q; mdst = D_T; end
      OP_Z1:       begin mx = {1'b0, ss}; my = v; mm = q; mdst = D_Z1; end
      OP_Z2:       begin mx = {1'b0, q - sr}; my = v; mm = q; mdst = D_Z2; end
      OP_PROD:     begin mx = {1'b0, pa}; my = pres; mm = p; mdst = D_PRES; end
      OP_U:        begin mx = {1'b0, pres}; mm = q; mdst = D_PRES; end
      default:     mul_go = 1'b0;
    endcase
  end

  dsv_modmul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .x     (mx),
    .y     (my),
    .m     (mm),
    .done  (mul_done),
    .res   (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      h         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (mul_go) dst <= mdst;
      case (cmd.op)
        OP_LOAD: begin
          act  <= in_action;
          sym  <= in_symbol;
          last <= in_last;
          k    <= in_nonce & op_mask;
          sr   <= in_sig_r & op_mask;
          ss   <= in_sig_s & op_mask;
        end
        OP_FINISH_HASH: begin hf <= h; h <= '0; end
        OP_HM_FIX:     if (hm == '0) hm <= 32'd1;
        OP_POW_SET_R:  begin pb <= a;    pe <= k;        pmsel <= 1'b0; end
        OP_POW_SET_V:  begin pb <= hm;   pe <= q - 32'd2; pmsel <= 1'b1; end
        OP_POW_SET_Z1: begin pb <= a;    pe <= z1;       pmsel <= 1'b0; end
        OP_POW_SET_Z2: begin pb <= ykey; pe <= z2;       pmsel <= 1'b0; end
        OP_POW_INIT:   pres <= (pmod == '0) ? '0 : 32'd1;
        OP_POW_SHIFT:  pe <= pe >> 1;
        OP_SAVE_R:     r <= pres;
        OP_SAVE_V:     v <= pres;
        OP_SAVE_PA:    pa <= pres;
        OP_S_ADD:      s <= (s_sum >= {1'b0, q}) ? WORD_W'(s_sum - {1'b0, q})
                                                 : s_sum[WORD_W-1:0];
        OP_EMIT_NONCE: begin
          out_valid <= 1'b1; out_status <= ST_NONCE; out_r <= '0; out_s <= '0;
          out_hash <= hf;
        end
        OP_EMIT_RZERO: begin
          out_valid <= 1'b1; out_status <= ST_R_ZERO; out_r <= '0; out_s <= '0;
          out_hash <= hf;
        end
        OP_EMIT_SZERO: begin
          out_valid <= 1'b1; out_status <= ST_S_ZERO; out_r <= r; out_s <= '0;
          out_hash <= hf;
        end
        OP_EMIT_SIGN: begin
          out_valid <= 1'b1; out_status <= ST_OK; out_r <= r; out_s <= s;
          out_hash <= hf;
        end
        OP_EMIT_RANGE: begin
          out_valid <= 1'b1; out_status <= ST_RANGE; out_r <= '0; out_s <= '0;
          out_hash <= hf;
        end
        OP_EMIT_VERIFY: begin
          out_valid <= 1'b1; out_status <= (pres == sr) ? ST_OK : ST_INVALID;
          out_r <= pres; out_s <= '0; out_hash <= hf;
        end
        default: ;
      endcase
      if (mul_done) begin
        case (dst)
          D_SUM:   sum <= mres;
          D_H:     h <= mres;
          D_HM:    hm <= mres;
          D_R:     r <= mres;
          D_S:     s <= mres;
          D_T:     t <= mres;
          D_Z1:    z1 <= mres;
          D_Z2:    z2 <= mres;
          D_PB:    pb <= mres;
          D_PRES:  pres <= mres;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    flags.mul_done  = mul_done;
    flags.last      = last;
    flags.act       = act;
    flags.foreign   = {{(WORD_W-SYM_W){1'b0}}, sym} >= WORD_W'(SYMBOL_COUNT);
    flags.k_bad     = (k == '0) || (k >= q);
    flags.sig_bad   = (sr == '0) || (sr >= q) || (ss == '0) || (ss >= q);
    flags.pmod_zero = (pmod == '0);
    flags.pe_zero   = (pe == '0);
    flags.pe_lsb    = pe[0];
    flags.r_zero    = (r == '0);
    flags.s_zero    = (s == '0);
    flags.p_zero    = (p == '0);
    flags.out_full  = out_valid;
  end

  logic emit_any;
  assign emit_any = (cmd.op == OP_EMIT_NONCE) || (cmd.op == OP_EMIT_RZERO) ||
                    (cmd.op == OP_EMIT_SZERO) || (cmd.op == OP_EMIT_SIGN) ||
                    (cmd.op == OP_EMIT_RANGE) || (cmd.op == OP_EMIT_VERIFY);

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(emit_any && out_valid && !out_ready))
    else $error("result overwritten while held");
  a_mul_not_instant: assert property (@(posedge clk) disable iff (rst)
    mul_go |=> !mul_done)
    else $error("multiplier finished too early");
  a_hash_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH_HASH) |=> (h == '0))
    else $error("hash not cleared after last beat");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status <= ST_NONCE))
    else $error("status code out of range");

endmodule

// File: rtl/core/dsv_ctrl.sv
module dsv_ctrl import dsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_fire,
  input  flags_t flags,
  output logic   in_ready,
  output cmd_t   cmd
);

  state_t state, state_next;
  state_t ret, ret_next;
  state_t pow_ret, pow_ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      pow_ret <= S_IDLE;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      pow_ret <= pow_ret_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    pow_ret_next = pow_ret;
    unique case (state)
      S_IDLE:       if (in_fire) state_next = S_START;
      S_START:      state_next = flags.foreign ? S_CHECK_LAST : S_HASH_ADD;
      S_HASH_ADD:   begin state_next = S_MWAIT; ret_next = S_HASH_SQR; end
      S_HASH_SQR:   begin state_next = S_MWAIT; ret_next = S_CHECK_LAST; end
      S_MWAIT:      if (flags.mul_done) state_next = ret;
      S_CHECK_LAST: begin
        if (!flags.last) state_next = S_IDLE;
        else state_next = flags.act ? S_VER_CHK : S_SIGN_CHK;
      end
      S_SIGN_CHK:   state_next = flags.k_bad ? S_EMIT_NONCE : S_HM_RED;
      S_VER_CHK:    state_next = flags.sig_bad ? S_EMIT_RANGE : S_HM_RED;
      S_HM_RED:     begin state_next = S_MWAIT; ret_next = S_HM_FIX; end
      S_HM_FIX:     state_next = flags.act ? S_V_SET : S_R_SET;
      S_R_SET:      begin state_next = S_POW_INIT; pow_ret_next = S_R_SAVE; end
      S_R_SAVE:     state_next = S_R_RED;
      S_R_RED:      begin state_next = S_MWAIT; ret_next = S_R_CHK; end
      S_R_CHK:      state_next = flags.r_zero ? S_EMIT_RZERO : S_XR;
      S_XR:         begin state_next = S_MWAIT; ret_next = S_KH; end
      S_KH:         begin state_next = S_MWAIT; ret_next = S_S_ADD; end
      S_S_ADD:      state_next = S_S_CHK;
      S_S_CHK:      state_next = flags.s_zero ? S_EMIT_SZERO : S_EMIT_SIGN;
      S_V_SET:      begin state_next = S_POW_INIT; pow_ret_next = S_V_SAVE; end
      S_V_SAVE:     state_next = S_Z1;
      S_Z1:         begin state_next = S_MWAIT; ret_next = S_Z2; end
      S_Z2:         begin state_next = S_MWAIT; ret_next = S_PA_SET; end
      S_PA_SET:     begin state_next = S_POW_INIT; pow_ret_next = S_PA_SAVE; end
      S_PA_SAVE:    state_next = S_PY_SET;
      S_PY_SET:     begin state_next = S_POW_INIT; pow_ret_next = S_PROD_CHK; end
      S_PROD_CHK:   state_next = flags.p_zero ? S_U : S_PROD;
      S_PROD:       begin state_next = S_MWAIT; ret_next = S_U; end
      S_U:          begin state_next = S_MWAIT; ret_next = S_EMIT_VERIFY; end
      S_POW_INIT:   state_next = flags.pmod_zero ? pow_ret : S_POW_BASE;
      S_POW_BASE:   begin state_next = S_MWAIT; ret_next = S_POW_LOOP; end
      S_POW_LOOP: begin
        if (flags.pe_zero) state_next = pow_ret;
        else state_next = flags.pe_lsb ? S_POW_MUL : S_POW_SQR;
      end
      S_POW_MUL:    begin state_next = S_MWAIT; ret_next = S_POW_SQR; end
      S_POW_SQR:    begin state_next = S_MWAIT; ret_next = S_POW_SHIFT; end
      S_POW_SHIFT:  state_next = S_POW_LOOP;
      S_EMIT_NONCE, S_EMIT_RZERO, S_EMIT_SZERO, S_EMIT_SIGN, S_EMIT_RANGE,
      S_EMIT_VERIFY: if (!flags.out_full) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) cmd.op = OP_LOAD;
      end
      S_HASH_ADD:    cmd.op = OP_HASH_ADD;
      S_HASH_SQR:    cmd.op = OP_HASH_SQR;
      S_CHECK_LAST:  if (flags.last) cmd.op = OP_FINISH_HASH;
      S_HM_RED:      cmd.op = OP_HM_RED;
      S_HM_FIX:      cmd.op = OP_HM_FIX;
      S_R_SET:       cmd.op = OP_POW_SET_R;
      S_R_SAVE:      cmd.op = OP_SAVE_R;
      S_R_RED:       cmd.op = OP_R_RED;
      S_XR:          cmd.op = OP_XR;
      S_KH:          cmd.op = OP_KH;
      S_S_ADD:       cmd.op = OP_S_ADD;
      S_V_SET:       cmd.op = OP_POW_SET_V;
      S_V_SAVE:      cmd.op = OP_SAVE_V;
      S_Z1:          cmd.op = OP_Z1;
      S_Z2:          cmd.op = OP_Z2;
      S_PA_SET:      cmd.op = OP_POW_SET_Z1;
      S_PA_SAVE:     cmd.op = OP_SAVE_PA;
      S_PY_SET:      cmd.op = OP_POW_SET_Z2;
      S_PROD:        cmd.op = OP_PROD;
      S_U:           cmd.op = OP_U;
      S_POW_INIT:    cmd.op = OP_POW_INIT;
      S_POW_BASE:    cmd.op = OP_POW_BASE;
      S_POW_MUL:     cmd.op = OP_POW_MUL;
      S_POW_SQR:     cmd.op = OP_POW_SQR;
      S_POW_SHIFT:   cmd.op = OP_POW_SHIFT;
      S_EMIT_NONCE:  if (!flags.out_full) cmd.op = OP_EMIT_NONCE;
      S_EMIT_RZERO:  if (!flags.out_full) cmd.op = OP_EMIT_RZERO;
      S_EMIT_SZERO:  if (!flags.out_full) cmd.op = OP_EMIT_SZERO;
      S_EMIT_SIGN:   if (!flags.out_full) cmd.op = OP_EMIT_SIGN;
      S_EMIT_RANGE:  if (!flags.out_full) cmd.op = OP_EMIT_RANGE;
      S_EMIT_VERIFY: if (!flags.out_full) cmd.op = OP_EMIT_VERIFY;
      default:       cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/core/dlog_signature_sign_verify.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata: symbol, nonce, sig_r, sig_s; tuser: action; tlast: last
// m_axis    out        tdata: status, out_r, out_s, message_hash
// apb       in         six 32-bit registers at byte addresses 0, 4, ..., 20
//
// A symbol beat takes two modular multiplies (none if the symbol is >= SYMBOL_COUNT),
// each 33 shift-add steps (a double, then a conditional add) in the shared multiplier.
// The last beat adds one modular power when signing and three when verifying, each up
// to 65 multiplies, plus up to four (sign) or five (verify) single multiplies.
// One beat is worked at a time; s_tready is high only while idle. A result holds in the
// output register until taken; the next beat is accepted meanwhile.
// Synchronous reset clears control and the running hash; no clearing pass.
module dlog_signature_sign_verify import dsv_pkg::*; #(
  parameter int MOD_BITS     = MOD_BITS_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // symbol[4:0], nonce[36:5], sig_r[68:37], sig_s[100:69]
  input  logic         s_tuser,  // action
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // status[2:0], out_r[34:3], out_s[66:35], hash[98:67]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [WORD_W-1:0] OP_MASK = WORD_W'((64'd1 << MOD_BITS) - 64'd1);

  logic [WORD_W-1:0] prime_p, prime_q, generator_a, secret_key, public_key, hash_modulus;
  logic [2:0]        reg_idx;
  logic              in_fire;
  cmd_t              cmd;
  flags_t            flags;
  logic [2:0]        out_status;
  logic [WORD_W-1:0] out_r, out_s, out_hash;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign in_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_p      <= '0;
      prime_q      <= '0;
      generator_a  <= '0;
      secret_key   <= '0;
      public_key   <= '0;
      hash_modulus <= HASH_MOD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_PRIME_P:     prime_p      <= pwdata;
        REG_PRIME_Q:     prime_q      <= pwdata;
        REG_GENERATOR_A: generator_a  <= pwdata;
        REG_SECRET_KEY:  secret_key   <= pwdata;
        REG_PUBLIC_KEY:  public_key   <= pwdata;
        REG_HASH_MOD:    hash_modulus <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRIME_P:     prdata = prime_p;
      REG_PRIME_Q:     prdata = prime_q;
      REG_GENERATOR_A: prdata = generator_a;
      REG_SECRET_KEY:  prdata = secret_key;
      REG_PUBLIC_KEY:  prdata = public_key;
      REG_HASH_MOD:    prdata = hash_modulus;
      default:         prdata = '0;
    endcase
  end

  dsv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .flags    (flags),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  dsv_datapath #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .flags        (flags),
    .p            (prime_p & OP_MASK),
    .q            (prime_q & OP_MASK),
    .a            (generator_a & OP_MASK),
    .xkey         (secret_key & OP_MASK),
    .ykey         (public_key & OP_MASK),
    .hash_mod_raw (hash_modulus),
    .op_mask      (OP_MASK),
    .in_action    (s_tuser),
    .in_symbol    (s_tdata[4:0]),
    .in_last      (s_tlast),
    .in_nonce     (s_tdata[36:5]),
    .in_sig_r     (s_tdata[68:37]),
    .in_sig_s     (s_tdata[100:69]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_status   (out_status),
    .out_r        (out_r),
    .out_s        (out_s),
    .out_hash     (out_hash)
  );

  assign m_tdata = {5'd0, out_hash, out_s, out_r, out_status};

endmodule

// File: tb/tb.sv
module tb;
  import dsv_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] sig_r;
    logic [31:0] sig_s;
    logic [31:0] digest;
  } sig_result_t;

  class sig_scoreboard;
    logic [31:0] regs [6];
    logic [31:0] digest_acc;
    sig_result_t pending_q [$];
    int errors;
    int n_checked;
    int n_sign;
    int n_verify;
    int n_status [8];

    function new();
      regs[REG_PRIME_P] = 0;
      regs[REG_PRIME_Q] = 0;
      regs[REG_GENERATOR_A] = 0;
      regs[REG_SECRET_KEY] = 0;
      regs[REG_PUBLIC_KEY] = 0;
      regs[REG_HASH_MOD] = HASH_MOD_RESET;
      digest_acc = 0;
      errors = 0;
      n_checked = 0;
      n_sign = 0;
      n_verify = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                      longint unsigned m);
      longint unsigned acc;
      if (m == 0) return 0;
      acc = 1;
      b = b % m;
      while (e != 0) begin
        if (e[0]) acc = (acc * b) % m;
        b = (b * b) % m;
        e = e >> 1;
      end
      return acc;
    endfunction

    function logic [31:0] digest_step(logic [31:0] h, logic [4:0] sym);
      longint unsigned m, sum;
      m = regs[REG_HASH_MOD];
      if (m < HASH_MIN_MOD) m = HASH_FALLBACK_MOD;
      sum = (longint'(h) + sym + 1) % m;
      return 32'((sum * sum) % m);
    endfunction

    function longint unsigned reduce_digest(logic [31:0] h);
      longint unsigned hm;
      hm = h % regs[REG_PRIME_Q];
      if (hm == 0) hm = 1;
      return hm;
    endfunction

    function sig_result_t sign_digest(logic [31:0] h, logic [31:0] k);
      sig_result_t res;
      longint unsigned q, rr, ss, hm;
      q = regs[REG_PRIME_Q];
      res.status = ST_OK;
      res.sig_r = 0;
      res.sig_s = 0;
      res.digest = h;
      if (k == 0 || k >= q) begin
        res.status = ST_NONCE;
      end else begin
        hm = reduce_digest(h);
        rr = mod_pow(regs[REG_GENERATOR_A], k, regs[REG_PRIME_P]) % q;
        if (rr == 0) begin
          res.status = ST_R_ZERO;
        end else begin
          ss = (((longint'(regs[REG_SECRET_KEY]) * rr) % q) + ((longint'(k) * hm) % q)) % q;
          res.sig_r = 32'(rr);
          if (ss == 0) res.status = ST_S_ZERO;
          else res.sig_s = 32'(ss);
        end
      end
      return res;
    endfunction

    function sig_result_t verify_digest(logic [31:0] h, logic [31:0] rr, logic [31:0] ss);
      sig_result_t res;
      longint unsigned p, q, hm, v, z1, z2, prod, u;
      p = regs[REG_PRIME_P];
      q = regs[REG_PRIME_Q];
      res.status = ST_RANGE;
      res.sig_r = 0;
      res.sig_s = 0;
      res.digest = h;
      if (!(rr == 0 || rr >= q || ss == 0 || ss >= q)) begin
        hm = reduce_digest(h);
        v = mod_pow(hm, q - 2, q);
        z1 = (longint'(ss) * v) % q;
        z2 = (((q - rr) % q) * v) % q;
        if (p == 0) prod = 0;
        else prod = (mod_pow(regs[REG_GENERATOR_A], z1, p) *
                     mod_pow(regs[REG_PUBLIC_KEY], z2, p)) % p;
        u = prod % q;
        res.sig_r = 32'(u);
        res.status = (u == rr) ? ST_OK : ST_INVALID;
      end
      return res;
    endfunction

    function void note_beat(logic act, logic [4:0] sym, logic lst, logic [31:0] k,
                            logic [31:0] rr, logic [31:0] ss);
      digest_acc = digest_step(digest_acc, sym);
      if (!lst) return;
      if (act) begin
        pending_q.push_back(verify_digest(digest_acc, rr, ss));
        n_verify++;
      end else begin
        pending_q.push_back(sign_digest(digest_acc, k));
        n_sign++;
      end
      digest_acc = 0;
    endfunction

    function void check_result(logic [103:0] d);
      sig_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", d);
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      n_status[e.status]++;
      if (d[2:0] !== e.status || d[34:3] !== e.sig_r || d[66:35] !== e.sig_s ||
          d[98:67] !== e.digest) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d r=%h s=%h h=%h got st=%0d r=%h s=%h h=%h",
                   e.status, e.sig_r, e.sig_s, e.digest,
                   d[2:0], d[34:3], d[66:35], d[98:67]);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser, s_tlast;
  logic [103:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [103:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  dlog_signature_sign_verify dut (.*);

  sig_scoreboard sb = new();
  int tx_idle = 34, rx_idle = 53;
  int stall_count = 0;
  int n_beats = 0;
  localparam int STALL_LIMIT = 400000;

  longint unsigned grp_p [5] = '{23, 607, 7919, 2147483647, 4294967291};
  longint unsigned grp_q [5] = '{11, 101, 107, 331, 22605091};

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || rst) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count > STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_beat(logic act, logic [4:0] sym, logic lst, logic [31:0] k,
                           logic [31:0] rr, logic [31:0] ss);
    while ($urandom_range(99) < tx_idle) begin
      @(negedge clk);
      s_tvalid = 0;
    end
    @(negedge clk);
    s_tvalid = 1;
    s_tuser = act;
    s_tlast = lst;
    s_tdata = {3'b0, ss, rr, k, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_beat(act, sym, lst, k, rr, ss);
    n_beats++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    sb.regs[idx] = val;
  endtask

  task automatic load_group(logic [31:0] p, logic [31:0] q, logic [31:0] hmod);
    logic [31:0] a, x;
    a = 32'(sb.mod_pow(2, (p - 1) / q, p));
    if (a == 1) a = 32'(sb.mod_pow(3, (p - 1) / q, p));
    x = $urandom_range(q - 1, 1);
    write_reg(REG_PRIME_P, p);
    write_reg(REG_PRIME_Q, q);
    write_reg(REG_GENERATOR_A, a);
    write_reg(REG_SECRET_KEY, x);
    write_reg(REG_PUBLIC_KEY,
              ($urandom_range(9) == 0) ? $urandom : 32'(sb.mod_pow(a, x, p)));
    write_reg(REG_HASH_MOD, hmod);
  endtask

  // Send one message; the final beat carries sign or verify with the given operands.
  task automatic send_message(logic [4:0] syms [$], logic act, logic [31:0] k,
                              logic [31:0] rr, logic [31:0] ss);
    foreach (syms[i]) begin
      if (i == syms.size() - 1) send_beat(act, syms[i], 1'b1, k, rr, ss);
      else send_beat(1'($urandom), syms[i], 1'b0, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic random_message();
    logic [4:0] syms [$];
    logic [31:0] h, k, rr, ss, q;
    sig_result_t sg;
    int len, pick;
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
    h = 0;
    repeat (len) begin
      syms.push_back(5'($urandom));
      h = sb.digest_step(h, syms[$]);
    end
    q = sb.regs[REG_PRIME_Q];
    pick = $urandom_range(99);
    k = $urandom_range(q - 1, 1);
    if ($urandom_range(1) == 0) begin
      if (pick < 8) k = 0;
      else if (pick < 16) k = $urandom;
      send_message(syms, 1'b0, k, $urandom, $urandom);
    end else begin
      sg = sb.sign_digest(h, k);
      rr = sg.sig_r;
      ss = sg.sig_s;
      if (pick < 20) ss = (ss + 1) % q;
      else if (pick < 30) rr = $urandom_range(q - 1, 1);
      else if (pick < 36) rr = $urandom;
      else if (pick < 42) ss = $urandom;
      else if (pick < 46) ss = q;
      send_message(syms, 1'b1, $urandom, rr, ss);
    end
  endtask

  initial begin
    logic [4:0] one [$];
    logic [4:0] ext [$];
    int g, items;
    rst = 1;
    s_tvalid = 0;
    s_tuser = 0;
    s_tlast = 0;
    s_tdata = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    one = '{5'd0};
    ext = '{5'd31, 5'd0, 5'd31};
    send_message(one, 1'b0, 32'd5, 0, 0);
    send_message(ext, 1'b1, 0, 32'd3, 32'd4);
    drain();
    load_group(23, 11, 5);
    send_message(ext, 1'b0, 0, 0, 0);
    send_message(one, 1'b0, 32'd11, 0, 0);
    send_message(one, 1'b0, 32'hFFFFFFFF, 0, 0);
    send_message(ext, 1'b0, 32'd10, 0, 0);
    send_message(one, 1'b0, 32'd1, 0, 0);
    send_message(one, 1'b1, 0, 0, 32'd2);
    send_message(one, 1'b1, 0, 32'd2, 32'd11);
    send_message(one, 1'b1, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_message(one, 1'b1, 0, 32'd10, 32'd10);
    drain();
    write_reg(REG_PRIME_P, 0);
    write_reg(REG_HASH_MOD, 32'hFFFFFFFF);
    send_message(ext, 1'b0, 32'd7, 0, 0);
    send_message(ext, 1'b1, 0, 32'd3, 32'd9);
    drain();
    load_group(32'd4294967291, 32'd4294967291, 32'd31);
    send_message(one, 1'b0, 32'hFFFFFFFA, 0, 0);
    send_message(one, 1'b1, 0, 32'hFFFFFFFA, 32'h7FFFFFFF);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      if (mode == 1) begin
        tx_idle = 53;
        rx_idle = 34;
      end else if (mode == 2) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      for (g = 0; g < 5; g++) begin
        case ($urandom_range(3))
          0: load_group(32'(grp_p[g]), 32'(grp_q[g]), HASH_MOD_RESET);
          1: load_group(32'(grp_p[g]), 32'(grp_q[g]), $urandom_range(31));
          2: load_group(32'(grp_p[g]), 32'(grp_q[g]), 32'd32);
          default: load_group(32'(grp_p[g]), 32'(grp_q[g]), $urandom);
        endcase
        items = n_beats + ((g == 4) ? 20 : 77);
        while (n_beats < items) random_message();
        drain();
      end
    end

    $display("covered %0d beats: %0d sign and %0d verify jobs, %0d results checked",
             n_beats, sb.n_sign, sb.n_verify, sb.n_checked);
    $display("status mix ok=%0d invalid=%0d rzero=%0d szero=%0d range=%0d nonce=%0d",
             sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3],
             sb.n_status[4], sb.n_status[5]);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: dlog_signature_sign_verify.f
rtl/core/dsv_pkg.sv
rtl/core/dsv_modmul.sv
rtl/core/dsv_datapath.sv
rtl/core/dsv_ctrl.sv
rtl/core/dlog_signature_sign_verify.sv
tb/tb.sv
